FILE: src/prefix_code_pixel_decoder_defines.svh
// Assertion macros shared by the decoder RTL.
// Both expect clk and rst_n to be visible in the module that uses them.
`ifndef PREFIX_CODE_PIXEL_DECODER_DEFINES_SVH
`define PREFIX_CODE_PIXEL_DECODER_DEFINES_SVH

// same-cycle implication
`define PCD_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pcd check failed (same cycle)");

// next-cycle implication
`define PCD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pcd check failed (next cycle)");

`endif

FILE: src/pcd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pcd_pkg;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_BIT  = 1'b1;

    localparam logic [12:0] DIM_MAX = 13'd4096;

    typedef enum logic [1:0] {
        CFG_IMAGE_WIDTH    = 2'd0,
        CFG_IMAGE_HEIGHT   = 2'd1,
        CFG_CODE_LIMIT     = 2'd2,
        CFG_ENTRIES_IN_USE = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        ST_PIXEL   = 2'd0,
        ST_NO_CODE = 2'd1,
        ST_BEYOND  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SEARCH,
        BK_DONE
    } back_state_t;

    typedef struct packed {
        logic [12:0] image_width;
        logic [12:0] image_height;
        logic [4:0]  code_limit;
        logic [8:0]  entries_in_use;
    } cfg_t;

    // classified input beat, as queued between front and back
    typedef struct packed {
        logic        is_load;
        logic        in_range;
        logic [7:0]  index;
        logic [7:0]  value;
        logic [15:0] code;
        logic [4:0]  length;
        logic        code_bit;
    } item_t;

    typedef struct packed {
        status_t     status;
        logic [7:0]  pixel_value;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [11:0] row;
        logic [11:0] column;
        logic        last;
    } result_t;

endpackage

`default_nettype wire

FILE: src/pcd_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface pcd_in_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [7:0]  entry_index;
    logic [7:0]  entry_value;
    logic [15:0] entry_code;
    logic [4:0]  entry_length;
    logic        code_bit;

    modport source (output valid, action, entry_index, entry_value, entry_code,
                    entry_length, code_bit, input ready);
    modport sink   (input valid, action, entry_index, entry_value, entry_code,
                    entry_length, code_bit, output ready);
endinterface

interface pcd_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [7:0]  pixel_value;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [11:0] row;
    logic [11:0] column;
    logic        last;

    modport source (output valid, status, pixel_value, red, green, blue, row, column,
                    last, input ready);
    modport sink   (input valid, status, pixel_value, red, green, blue, row, column,
                    last, output ready);
endinterface

`default_nettype wire

FILE: src/pcd_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module pcd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: src/pcd_front.sv
`timescale 1ns / 1ps
`default_nettype none
`include "prefix_code_pixel_decoder_defines.svh"

module pcd_front #(
    parameter int MAX_ENTRIES   = 256,
    parameter int MAX_CODE_BITS = 16
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    pcd_in_if.sink         stream,
    output logic           head_valid,
    output pcd_pkg::item_t head,
    input  wire logic      pop
);

    localparam logic [15:0] CODE_MASK = (MAX_CODE_BITS >= 16) ? 16'hFFFF :
                                        16'((32'd1 << MAX_CODE_BITS) - 32'd1);

    pcd_pkg::item_t slot_reg [2];
    pcd_pkg::item_t item;
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     count_reg, count_next;
    logic           push;

    assign stream.ready = (count_reg != 2'd2);
    assign push         = stream.valid && stream.ready;

    // classify: load or bit, slot range check, code trimmed to the code width
    always_comb
    begin
        item.is_load  = (stream.action == pcd_pkg::ACT_LOAD);
        item.in_range = (32'(stream.entry_index) < 32'(MAX_ENTRIES));
        item.index    = stream.entry_index;
        item.value    = stream.entry_value;
        item.code     = stream.entry_code & CODE_MASK;
        item.length   = stream.entry_length;
        item.code_bit = stream.code_bit;
    end

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= item;
        end
    end

    assign head_valid = (count_reg != 2'd0);
    assign head       = slot_reg[rd_ptr_reg];

    `PCD_ASSERT_IMPL(a_empty_ptrs_meet, count_reg == 2'd0, wr_ptr_reg == rd_ptr_reg)
    `PCD_ASSERT_IMPL(a_full_ptrs_meet, count_reg == 2'd2, wr_ptr_reg == rd_ptr_reg)
    `PCD_ASSERT_IMPL(a_no_pop_when_empty, pop, count_reg != 2'd0)

endmodule

`default_nettype wire

FILE: src/pcd_back.sv
`timescale 1ns / 1ps
`default_nettype none
`include "prefix_code_pixel_decoder_defines.svh"

module pcd_back #(
    parameter int MAX_ENTRIES   = 256,
    parameter int MAX_CODE_BITS = 16
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire pcd_pkg::cfg_t   cfg,
    input  wire logic            head_valid,
    input  wire pcd_pkg::item_t  head,
    output logic                 pop,
    pcd_out_if.source            pixels
);

    localparam int AW    = $clog2(MAX_ENTRIES);
    localparam int IW    = $clog2(MAX_ENTRIES + 1);
    localparam int ACW   = MAX_CODE_BITS;
    localparam int LW    = $clog2(MAX_CODE_BITS + 1);
    localparam int CW    = (MAX_CODE_BITS > 16) ? MAX_CODE_BITS : 16;
    localparam int RAM_W = 8 + 16 + 5;

    pcd_pkg::back_state_t state_reg, state_next;

    logic [ACW-1:0]   acc_reg, acc_next;
    logic [LW-1:0]    acc_len_reg, acc_len_next;
    logic [IW-1:0]    rd_idx_reg, rd_idx_next;
    logic             cmp_valid_reg, cmp_valid_next;
    logic             cmp_last_reg, cmp_last_next;
    logic             found_reg, found_next;
    logic [7:0]       value_reg, value_next;
    logic [12:0]      row_reg, row_next;
    logic [11:0]      col_reg, col_next;
    logic             out_valid_reg, out_valid_next;
    pcd_pkg::result_t out_reg, out_next;

    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [RAM_W-1:0] ram_wdata;
    logic [RAM_W-1:0] ram_rdata;
    logic [7:0]       rd_value;
    logic [15:0]      rd_code;
    logic [4:0]       rd_len;

    logic [5:0]       lim;
    logic [IW-1:0]    searched;
    logic             issue;
    logic             match;
    logic [CW-1:0]    len_mask;
    logic             emit;
    logic             slot_free;
    logic             leave_search;
    logic [12:0]      w;
    logic [12:0]      h;
    logic [12:0]      col_inc;

    // table: {value, code, length}, one entry read per cycle during a search
    pcd_ram #(
        .WIDTH (RAM_W),
        .DEPTH (MAX_ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (rd_idx_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    assign ram_we    = (state_reg == pcd_pkg::BK_IDLE) && head_valid && head.is_load
                       && head.in_range;
    assign ram_waddr = AW'(head.index);
    assign ram_wdata = {head.value, head.code, head.length};
    assign rd_value  = ram_rdata[28:21];
    assign rd_code   = ram_rdata[20:5];
    assign rd_len    = ram_rdata[4:0];

    assign pop = (state_reg == pcd_pkg::BK_IDLE) && head_valid;

    always_comb
    begin
        if (6'(cfg.code_limit) > 6'(MAX_CODE_BITS))
        begin
            lim = 6'(MAX_CODE_BITS);
        end
        else
        begin
            lim = 6'(cfg.code_limit);
        end

        if (32'(cfg.entries_in_use) > 32'(MAX_ENTRIES))
        begin
            searched = IW'(MAX_ENTRIES);
        end
        else
        begin
            searched = IW'(cfg.entries_in_use);
        end

        if (cfg.image_width == 13'd0)
        begin
            w = 13'd1;
        end
        else if (cfg.image_width > pcd_pkg::DIM_MAX)
        begin
            w = pcd_pkg::DIM_MAX;
        end
        else
        begin
            w = cfg.image_width;
        end

        if (cfg.image_height == 13'd0)
        begin
            h = 13'd1;
        end
        else if (cfg.image_height > pcd_pkg::DIM_MAX)
        begin
            h = pcd_pkg::DIM_MAX;
        end
        else
        begin
            h = cfg.image_height;
        end
    end

    assign issue    = (rd_idx_reg < searched);
    assign len_mask = CW'(~({64{1'b1}} << rd_len));
    // accumulator bits above its length are zero, so equal length + masked code suffices
    assign match    = (rd_len != 5'd0) && (6'(rd_len) <= lim)
                      && (6'(rd_len) == 6'(acc_len_reg))
                      && ((CW'(rd_code) & len_mask) == CW'(acc_reg));
    assign leave_search = cmp_valid_reg && (match || cmp_last_reg);
    assign emit      = found_reg || (6'(acc_len_reg) >= lim);
    assign slot_free = !out_valid_reg || pixels.ready;
    assign col_inc   = {1'b0, col_reg} + 13'd1;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pcd_pkg::BK_IDLE:
            begin
                if (head_valid && !head.is_load)
                begin
                    state_next = (searched == '0) ? pcd_pkg::BK_DONE : pcd_pkg::BK_SEARCH;
                end
            end
            pcd_pkg::BK_SEARCH:
            begin
                if (leave_search)
                begin
                    state_next = pcd_pkg::BK_DONE;
                end
            end
            pcd_pkg::BK_DONE:
            begin
                if (!emit || slot_free)
                begin
                    state_next = pcd_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = pcd_pkg::BK_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        acc_next       = acc_reg;
        acc_len_next   = acc_len_reg;
        rd_idx_next    = rd_idx_reg;
        cmp_valid_next = 1'b0;
        cmp_last_next  = 1'b0;
        found_next     = found_reg;
        value_next     = value_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        out_valid_next = out_valid_reg && !pixels.ready;
        out_next       = out_reg;

        unique case (state_reg)
            pcd_pkg::BK_IDLE:
            begin
                if (head_valid && !head.is_load)
                begin
                    acc_next     = {acc_reg[ACW-2:0], head.code_bit};
                    acc_len_next = (acc_len_reg < LW'(MAX_CODE_BITS)) ?
                                   acc_len_reg + 1'b1 : acc_len_reg;
                    rd_idx_next  = '0;
                    found_next   = 1'b0;
                end
            end
            pcd_pkg::BK_SEARCH:
            begin
                if (issue)
                begin
                    rd_idx_next = rd_idx_reg + 1'b1;
                end
                cmp_valid_next = issue && !leave_search;
                cmp_last_next  = issue && (rd_idx_reg == searched - 1'b1);
                if (cmp_valid_reg && match)
                begin
                    found_next = 1'b1;
                    value_next = rd_value;
                end
            end
            pcd_pkg::BK_DONE:
            begin
                if (emit && slot_free)
                begin
                    acc_next       = '0;
                    acc_len_next   = '0;
                    out_valid_next = 1'b1;
                    out_next       = '0;
                    if (!found_reg)
                    begin
                        out_next.status = pcd_pkg::ST_NO_CODE;
                    end
                    else
                    begin
                        out_next.pixel_value = value_reg;
                        out_next.red         = value_reg + {value_reg[6:0], 1'b0};
                        out_next.green       = value_reg;
                        out_next.blue        = value_reg + {value_reg[4:0], 3'b000};
                        if (row_reg >= h)
                        begin
                            out_next.status = pcd_pkg::ST_BEYOND;
                        end
                        else
                        begin
                            out_next.status = pcd_pkg::ST_PIXEL;
                            out_next.row    = row_reg[11:0];
                            out_next.column = col_reg;
                            out_next.last   = (row_reg == h - 13'd1)
                                              && ({1'b0, col_reg} >= w - 13'd1);
                            if (col_inc >= w)
                            begin
                                col_next = '0;
                                row_next = row_reg + 13'd1;
                            end
                            else
                            begin
                                col_next = col_inc[11:0];
                            end
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pcd_pkg::BK_IDLE;
            acc_reg       <= '0;
            acc_len_reg   <= '0;
            rd_idx_reg    <= '0;
            cmp_valid_reg <= 1'b0;
            cmp_last_reg  <= 1'b0;
            found_reg     <= 1'b0;
            row_reg       <= '0;
            col_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            acc_len_reg   <= acc_len_next;
            rd_idx_reg    <= rd_idx_next;
            cmp_valid_reg <= cmp_valid_next;
            cmp_last_reg  <= cmp_last_next;
            found_reg     <= found_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        out_reg   <= out_next;
    end

    assign pixels.valid       = out_valid_reg;
    assign pixels.status      = out_reg.status;
    assign pixels.pixel_value = out_reg.pixel_value;
    assign pixels.red         = out_reg.red;
    assign pixels.green       = out_reg.green;
    assign pixels.blue        = out_reg.blue;
    assign pixels.row         = out_reg.row;
    assign pixels.column      = out_reg.column;
    assign pixels.last        = out_reg.last;

    `PCD_ASSERT_IMPL(a_cmp_only_in_search, cmp_valid_reg, state_reg == pcd_pkg::BK_SEARCH)
    `PCD_ASSERT_IMPL(a_search_has_bits, state_reg == pcd_pkg::BK_SEARCH, acc_len_reg != '0)
    `PCD_ASSERT_NEXT(a_emit_fills_output, (state_reg == pcd_pkg::BK_DONE) && emit && slot_free, out_valid_reg && (acc_len_reg == '0))

endmodule

`default_nettype wire

FILE: src/prefix_code_pixel_decoder.sv
// Prefix-code pixel decoder.
// stream (valid/ready): action 0 writes table slot entry_index with value, code
// and length; action 1 shifts code_bit into the code accumulator.
// pixels (valid/ready): one beat per matched code (status pixel, or status
// beyond-image once the row count reaches the height), or one status no-code
// beat when the accumulator reaches the code limit without a match.
// cfg_we/cfg_index/cfg_data write image_width, image_height, code_limit and
// entries_in_use; write them only while the decoder is idle.
// Beats pass a two-deep queue into the execution side; a load is written
// there from the idle state. A code bit reads the table memory one slot per
// cycle from slot 0 until the first match or the last slot in use
// (entries_in_use, capped at MAX_ENTRIES), and not at all with no slot in use.
// Results sit in an output register; while the receiver stalls, the decoder
// keeps taking bits that give no result, holds on the first one that has a
// result, and the queue fills until stream.ready drops.
// Reset clears the accumulator, pixel counters, queue and output valid and
// loads width 1, height 1, code limit 16, no entries in use. Table contents
// are not cleared: load every searched slot before sending code bits.
`timescale 1ns / 1ps
`default_nettype none

module prefix_code_pixel_decoder #(
    parameter int MAX_ENTRIES   = 256,
    parameter int MAX_CODE_BITS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    pcd_in_if.sink           stream,
    pcd_out_if.source        pixels,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [12:0] cfg_data
);

    pcd_pkg::cfg_t  cfg_reg;
    logic           head_valid;
    pcd_pkg::item_t head;
    logic           pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.image_width    <= 13'd1;
            cfg_reg.image_height   <= 13'd1;
            cfg_reg.code_limit     <= 5'd16;
            cfg_reg.entries_in_use <= 9'd0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                pcd_pkg::CFG_IMAGE_WIDTH:    cfg_reg.image_width    <= cfg_data;
                pcd_pkg::CFG_IMAGE_HEIGHT:   cfg_reg.image_height   <= cfg_data;
                pcd_pkg::CFG_CODE_LIMIT:     cfg_reg.code_limit     <= cfg_data[4:0];
                pcd_pkg::CFG_ENTRIES_IN_USE: cfg_reg.entries_in_use <= cfg_data[8:0];
                default:
                begin
                end
            endcase
        end
    end

    pcd_front #(
        .MAX_ENTRIES   (MAX_ENTRIES),
        .MAX_CODE_BITS (MAX_CODE_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .stream     (stream),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop)
    );

    pcd_back #(
        .MAX_ENTRIES   (MAX_ENTRIES),
        .MAX_CODE_BITS (MAX_CODE_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .pixels     (pixels)
    );

endmodule

`default_nettype wire

FILE: verif/tb_prefix_code_pixel_decoder.sv
`timescale 1ns / 1ps

module tb_prefix_code_pixel_decoder;
    import pcd_pkg::*;

    localparam int TABLE_DEPTH = 256;
    localparam int CODE_BITS   = 16;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [12:0] cfg_data;

    pcd_in_if  stream_bus();
    pcd_out_if pixel_bus();

    prefix_code_pixel_decoder u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .stream    (stream_bus),
        .pixels    (pixel_bus),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // mirror of the code table and decoder state
    logic [15:0] slot_code   [TABLE_DEPTH];
    logic [4:0]  slot_len    [TABLE_DEPTH];
    logic [7:0]  slot_value  [TABLE_DEPTH];
    bit          slot_loaded [TABLE_DEPTH];
    logic [15:0] acc_bits;
    int          acc_len;
    int          row_cnt;
    int          col_cnt;
    int unsigned img_width;
    int unsigned img_height;
    int unsigned code_limit;
    int unsigned entries_used;

    result_t     pending_pixels[$];
    int          errors;
    int          gap_pct;
    int          stall_pct;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic int dim_clamp(int unsigned v);
        if (v == 0)
            return 1;
        if (v > 4096)
            return 4096;
        return v;
    endfunction

    function automatic int eff_limit();
        return (code_limit > CODE_BITS) ? CODE_BITS : code_limit;
    endfunction

    function automatic int searched_slots();
        return (entries_used > TABLE_DEPTH) ? TABLE_DEPTH : entries_used;
    endfunction

    function automatic void predict_beat(logic action, logic [7:0] idx, logic [7:0] val,
                                         logic [15:0] code, logic [4:0] len,
                                         logic code_bit);
        int          lim;
        int          hit;
        int          w;
        int          h;
        logic [31:0] mask;
        result_t     px;
        px = '0;
        if (action == ACT_LOAD)
        begin
            slot_value[idx]  = val;
            slot_code[idx]   = code;
            slot_len[idx]    = len;
            slot_loaded[idx] = 1'b1;
            return;
        end
        lim      = eff_limit();
        acc_bits = {acc_bits[14:0], code_bit};
        if (acc_len < CODE_BITS)
            acc_len++;
        hit = -1;
        for (int i = 0; i < searched_slots() && hit < 0; i++)
        begin
            mask = (32'd1 << slot_len[i]) - 32'd1;
            if (slot_len[i] != 0 && slot_len[i] <= lim && slot_len[i] == acc_len
                && (slot_code[i] & mask[15:0]) == acc_bits)
                hit = i;
        end
        if (hit < 0)
        begin
            // accumulator hit the limit with no match: flag and restart
            if (acc_len >= lim)
            begin
                acc_bits  = '0;
                acc_len   = 0;
                px.status = ST_NO_CODE;
                pending_pixels.push_back(px);
            end
            return;
        end
        acc_bits       = '0;
        acc_len        = 0;
        px.pixel_value = slot_value[hit];
        px.red         = slot_value[hit] * 8'd3;
        px.green       = slot_value[hit];
        px.blue        = slot_value[hit] * 8'd9;
        w = dim_clamp(img_width);
        h = dim_clamp(img_height);
        if (row_cnt >= h)
            px.status = ST_BEYOND;
        else
        begin
            px.status = ST_PIXEL;
            px.row    = 12'(row_cnt);
            px.column = 12'(col_cnt);
            px.last   = (row_cnt == h - 1 && col_cnt >= w - 1);
            col_cnt++;
            if (col_cnt >= w)
            begin
                col_cnt = 0;
                row_cnt++;
            end
        end
        pending_pixels.push_back(px);
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    always @(posedge clk)
    begin : pixel_check
        result_t want;
        if (rst_n && pixel_bus.valid && pixel_bus.ready)
        begin
            if (pending_pixels.size() == 0)
            begin
                $error("pixel beat with nothing expected: status %0d value %0d",
                       pixel_bus.status, pixel_bus.pixel_value);
                errors++;
            end
            else
            begin
                want = pending_pixels.pop_front();
                check_field("status", want.status, pixel_bus.status);
                check_field("pixel_value", want.pixel_value, pixel_bus.pixel_value);
                check_field("red", want.red, pixel_bus.red);
                check_field("green", want.green, pixel_bus.green);
                check_field("blue", want.blue, pixel_bus.blue);
                check_field("row", want.row, pixel_bus.row);
                check_field("column", want.column, pixel_bus.column);
                check_field("last", want.last, pixel_bus.last);
            end
        end
    end

    // receiver: random stall bursts
    initial
    begin
        pixel_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_pct > 0 && $urandom_range(99) < stall_pct)
            begin
                pixel_bus.ready = 1'b0;
                repeat ($urandom_range(0, 17)) @(negedge clk);
            end
            else
                pixel_bus.ready = 1'b1;
        end
    end

    task automatic send_beat(input logic action, input logic [7:0] idx,
                             input logic [7:0] val, input logic [15:0] code,
                             input logic [4:0] len, input logic code_bit);
        @(negedge clk);
        if (gap_pct > 0 && $urandom_range(99) < gap_pct)
        begin
            stream_bus.valid = 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clk);
        end
        stream_bus.valid        = 1'b1;
        stream_bus.action       = action;
        stream_bus.entry_index  = idx;
        stream_bus.entry_value  = val;
        stream_bus.entry_code   = code;
        stream_bus.entry_length = len;
        stream_bus.code_bit     = code_bit;
        do
            @(posedge clk);
        while (!stream_bus.ready);
        predict_beat(action, idx, val, code, len, code_bit);
    endtask

    task automatic load_slot(input logic [7:0] idx, input logic [7:0] val,
                             input logic [15:0] code, input logic [4:0] len);
        send_beat(ACT_LOAD, idx, val, code, len, 1'($urandom));
    endtask

    // table fields of a bit beat are don't-care; fill them with noise
    task automatic send_bit(input logic b);
        send_beat(ACT_BIT, 8'($urandom), 8'($urandom), 16'($urandom), 5'($urandom), b);
    endtask

    task automatic hold_stream();
        @(negedge clk);
        stream_bus.valid = 1'b0;
    endtask

    task automatic wait_for_pixels();
        hold_stream();
        while (pending_pixels.size() != 0)
            @(negedge clk);
    endtask

    // a trailing bit with no result may still be searching the table
    task automatic settle();
        wait_for_pixels();
        repeat ((searched_slots() + 4) * 4 + 16) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input int unsigned value);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value[12:0];
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            CFG_IMAGE_WIDTH:    img_width    = value & 32'h1FFF;
            CFG_IMAGE_HEIGHT:   img_height   = value & 32'h1FFF;
            CFG_CODE_LIMIT:     code_limit   = value & 32'h1F;
            CFG_ENTRIES_IN_USE: entries_used = value & 32'h1FF;
            default: ;
        endcase
    endtask

    task automatic setup_image(input int unsigned w, input int unsigned h,
                               input int unsigned lim, input int unsigned n);
        settle();
        write_reg(CFG_IMAGE_WIDTH, w);
        write_reg(CFG_IMAGE_HEIGHT, h);
        write_reg(CFG_CODE_LIMIT, lim);
        write_reg(CFG_ENTRIES_IN_USE, n);
    endtask

    function automatic logic [4:0] pick_len();
        int lim;
        int r;
        lim = (eff_limit() < 1) ? 1 : eff_limit();
        r   = $urandom_range(99);
        if (r < 12)
            return 5'($urandom_range(0, 31));
        if (r < 60)
            return 5'($urandom_range(1, (lim < 5) ? lim : 5));
        return 5'($urandom_range(1, lim));
    endfunction

    // every searched slot must hold a loaded entry before bits arrive
    task automatic fill_table(input bit fresh);
        for (int i = 0; i < searched_slots(); i++)
            if (fresh || !slot_loaded[i])
                load_slot(8'(i), 8'($urandom), 16'($urandom), pick_len());
    endtask

    task automatic random_traffic(input int items);
        int sent;
        int r;
        int s;
        bit paused;
        sent   = 0;
        paused = 1'b0;
        while (sent < items)
        begin
            if (!paused && sent >= items / 2)
            begin
                wait_for_pixels();
                paused = 1'b1;
            end
            r = $urandom_range(99);
            if (r < 8)
            begin
                load_slot(8'($urandom), 8'($urandom), 16'($urandom), pick_len());
                sent++;
            end
            else if (r < 22 || searched_slots() == 0)
            begin
                send_bit(1'($urandom));
                sent++;
            end
            else
            begin
                // mostly whole codes taken from the table
                s = $urandom_range(searched_slots() - 1);
                if (slot_len[s] >= 1 && slot_len[s] <= eff_limit())
                begin
                    for (int k = slot_len[s] - 1; k >= 0; k--)
                    begin
                        send_bit(slot_code[s][k]);
                        sent++;
                    end
                end
                else
                begin
                    send_bit(1'($urandom));
                    sent++;
                end
            end
        end
    endtask

    task automatic test_directed_table();
        gap_pct   = 0;
        stall_pct = 0;
        setup_image(2, 1, 3, 6);
        load_slot(8'd0, 8'hFF, 16'hFFFF, 5'd1);   // "1", upper code bits ignored
        load_slot(8'd1, 8'h00, 16'hFFFD, 5'd2);   // "01"
        load_slot(8'd2, 8'hA5, 16'h0000, 5'd0);   // zero length never matches
        load_slot(8'd3, 8'h5A, 16'h0000, 5'd31);  // longer than any limit
        load_slot(8'd4, 8'h55, 16'h0001, 5'd3);   // "001"
        load_slot(8'd5, 8'h07, 16'h0001, 5'd1);   // shadowed by slot 0
        load_slot(8'd255, 8'h00, 16'h0000, 5'd16);
        send_bit(1'b1);
        send_bit(1'b0);
        send_bit(1'b1);                            // last pixel of the image
        send_bit(1'b0);
        send_bit(1'b0);
        send_bit(1'b1);                            // past the image
        send_bit(1'b0);
        send_bit(1'b0);
        send_bit(1'b0);                            // limit reached, no code
        settle();
        write_reg(CFG_CODE_LIMIT, 0);              // every unmatched bit flags
        send_bit(1'b1);
    endtask

    task automatic test_small_image();
        gap_pct   = 10;
        stall_pct = 10;
        setup_image(3, 2, 4, 4);
        fill_table(1'b1);
        random_traffic(150);
    endtask

    task automatic test_wide_image();
        gap_pct   = 15;
        stall_pct = 5;
        setup_image(4096, 4096, 16, 16);
        fill_table(1'b1);
        random_traffic(300);
    endtask

    task automatic test_dimension_clamp();
        gap_pct   = 5;
        stall_pct = 25;
        setup_image(0, 8191, 31, 8);
        fill_table(1'b1);
        random_traffic(250);
    endtask

    task automatic test_full_table();
        gap_pct   = 10;
        stall_pct = 10;
        setup_image(5, 4096, 16, 256);
        fill_table(1'b0);
        random_traffic(250);
    endtask

    task automatic test_capped_entries();
        gap_pct   = 20;
        stall_pct = 20;
        setup_image(8191, 0, 1, 511);
        fill_table(1'b0);
        random_traffic(150);
    endtask

    task automatic test_empty_table();
        gap_pct   = 30;
        stall_pct = 30;
        setup_image(7, 4096, 0, 0);
        random_traffic(40);
        setup_image(7, 4096, 2, 0);
        random_traffic(30);
    endtask

    task automatic test_random_setups();
        for (int p = 0; p < 4; p++)
        begin
            gap_pct   = (p == 3) ? 0 : $urandom_range(0, 25);
            stall_pct = (p == 3) ? 0 : $urandom_range(0, 25);
            setup_image($urandom_range(1, 16), $urandom_range(1, 4096),
                        $urandom_range(2, 16), $urandom_range(1, 24));
            fill_table($urandom_range(1));
            random_traffic(110);
        end
    endtask

    initial
    begin
        rst_n                   = 1'b0;
        cfg_we                  = 1'b0;
        cfg_index               = CFG_IMAGE_WIDTH;
        cfg_data                = '0;
        stream_bus.valid        = 1'b0;
        stream_bus.action       = ACT_LOAD;
        stream_bus.entry_index  = '0;
        stream_bus.entry_value  = '0;
        stream_bus.entry_code   = '0;
        stream_bus.entry_length = '0;
        stream_bus.code_bit     = 1'b0;
        acc_bits                = '0;
        acc_len                 = 0;
        row_cnt                 = 0;
        col_cnt                 = 0;
        img_width               = 1;
        img_height              = 1;
        code_limit              = 16;
        entries_used            = 0;
        errors                  = 0;
        gap_pct                 = 0;
        stall_pct               = 0;
        foreach (slot_loaded[i])
            slot_loaded[i] = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_table();
        test_small_image();
        test_wide_image();
        test_dimension_clamp();
        test_full_table();
        test_capped_entries();
        test_empty_table();
        test_random_setups();

        settle();
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #40_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
